// ----- design/sbct_pkg.sv -----
package sbct_pkg;

    localparam int CoordBits     = 24;
    localparam int SizeBits      = CoordBits - 1;
    localparam int VelBits       = 20;
    localparam int TimeFracBits  = 16;
    localparam int GapBits       = CoordBits + 3;
    localparam int MagBits       = GapBits - 1;
    localparam int QBits         = TimeFracBits + 2;
    localparam int TimeBits      = TimeFracBits + 4;
    localparam int StepsPerStage = 3;
    localparam int DivStages     = (QBits + StepsPerStage - 1) / StepsPerStage;

    localparam logic [QBits-1:0]    QLim   = QBits'(2) << TimeFracBits;
    localparam logic [TimeBits-1:0] TOne   = TimeBits'(1) << TimeFracBits;
    localparam logic [TimeBits-1:0] TInf   = TimeBits'(3) << TimeFracBits;

    localparam logic [1:0] NormPos  = 2'b01;
    localparam logic [1:0] NormNeg  = 2'b11;
    localparam logic [1:0] NormNone = 2'b00;

    typedef struct packed {
        logic [VelBits-1:0] rem;
        logic [1:0]         low;
        logic [VelBits-1:0] av;
        logic               sat;
        logic               neg;
        logic               vz;
    } sbct_lane_t;

    typedef struct packed {
        logic [QBits-1:0] q;
        logic             sat;
        logic             neg;
        logic             vz;
    } sbct_quot_t;

    typedef struct packed {
        logic gxe_neg;
        logic gye_neg;
        logic edge_eq;
    } sbct_flags_t;

endpackage

// ----- design/sbct_gap.sv -----
module sbct_gap (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [sbct_pkg::CoordBits-1:0] mover_x,
    input  logic signed [sbct_pkg::CoordBits-1:0] mover_y,
    input  logic        [sbct_pkg::SizeBits-1:0]  mover_width,
    input  logic        [sbct_pkg::SizeBits-1:0]  mover_height,
    input  logic signed [sbct_pkg::VelBits-1:0]   mover_vel_x,
    input  logic signed [sbct_pkg::VelBits-1:0]   mover_vel_y,
    input  logic signed [sbct_pkg::CoordBits-1:0] target_x,
    input  logic signed [sbct_pkg::CoordBits-1:0] target_y,
    input  logic        [sbct_pkg::SizeBits-1:0]  target_width,
    input  logic        [sbct_pkg::SizeBits-1:0]  target_height,
    output sbct_pkg::sbct_lane_t                  lane_xe,
    output sbct_pkg::sbct_lane_t                  lane_xx,
    output sbct_pkg::sbct_lane_t                  lane_ye,
    output sbct_pkg::sbct_lane_t                  lane_yx,
    output sbct_pkg::sbct_flags_t                 flags
);
    localparam int GB = sbct_pkg::GapBits;
    localparam int MB = sbct_pkg::MagBits;
    localparam int VB = sbct_pkg::VelBits;

    logic signed [GB-1:0] mx, my, mw, mh, tx, ty, tw, th;
    logic signed [GB-1:0] gxe_next, gxx_next, gye_next, gyx_next;
    logic signed [GB-1:0] gxe_reg, gxx_reg, gye_reg, gyx_reg;
    logic signed [VB-1:0] vx_reg, vy_reg;
    logic                 edge_reg;
    logic                 edge_b_reg;
    sbct_pkg::sbct_lane_t xe_reg, xx_reg, ye_reg, yx_reg;
    logic                 gxe_neg_reg, gye_neg_reg;

    function automatic sbct_pkg::sbct_lane_t mk_lane(logic signed [GB-1:0] g,
                                                     logic signed [VB-1:0] v);
        sbct_pkg::sbct_lane_t l;
        logic [MB-1:0] ag;
        logic [VB-1:0] av;
        ag    = g[GB-1] ? MB'(-g) : MB'(g);
        av    = v[VB-1] ? VB'(-v) : VB'(v);
        l.av  = av;
        l.sat = ag >= {{(MB-VB-2){1'b0}}, av, 2'b00};
        l.rem = ag[VB+1:2];
        l.low = ag[1:0];
        l.neg = g[GB-1] ^ v[VB-1];
        l.vz  = (v == '0);
        return l;
    endfunction

    always_comb begin
        mx = GB'(mover_x);
        my = GB'(mover_y);
        mw = GB'({1'b0, mover_width});
        mh = GB'({1'b0, mover_height});
        tx = GB'(target_x);
        ty = GB'(target_y);
        tw = GB'({1'b0, target_width});
        th = GB'({1'b0, target_height});
        if (mover_vel_x > 0) begin
            gxe_next = tx - (mx + mw);
            gxx_next = (tx + tw) - mx;
        end else begin
            gxe_next = (tx + tw) - mx;
            gxx_next = tx - (mx + mw);
        end
        if (mover_vel_y > 0) begin
            gye_next = (ty - th) - my;
            gyx_next = ty - (my - mh);
        end else begin
            gye_next = ty - (my - mh);
            gyx_next = (ty - th) - my;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gxe_reg     <= gxe_next;
            gxx_reg     <= gxx_next;
            gye_reg     <= gye_next;
            gyx_reg     <= gyx_next;
            vx_reg      <= mover_vel_x;
            vy_reg      <= mover_vel_y;
            edge_reg    <= ((my - mh) == ty);
            xe_reg      <= mk_lane(gxe_reg, vx_reg);
            xx_reg      <= mk_lane(gxx_reg, vx_reg);
            ye_reg      <= mk_lane(gye_reg, vy_reg);
            yx_reg      <= mk_lane(gyx_reg, vy_reg);
            gxe_neg_reg <= gxe_reg[GB-1];
            gye_neg_reg <= gye_reg[GB-1];
            edge_b_reg  <= edge_reg;
        end
    end

    assign lane_xe       = xe_reg;
    assign lane_xx       = xx_reg;
    assign lane_ye       = ye_reg;
    assign lane_yx       = yx_reg;
    assign flags.gxe_neg = gxe_neg_reg;
    assign flags.gye_neg = gye_neg_reg;
    assign flags.edge_eq = edge_b_reg;

endmodule

// ----- design/sbct_div.sv -----
module sbct_div (
    input  logic                 aclk,
    input  logic                 en,
    input  sbct_pkg::sbct_lane_t lane,
    output sbct_pkg::sbct_quot_t quot
);
    localparam int VB = sbct_pkg::VelBits;
    localparam int QB = sbct_pkg::QBits;
    localparam int NS = sbct_pkg::DivStages;
    localparam int SP = sbct_pkg::StepsPerStage;

    typedef struct packed {
        logic [VB-1:0] rem;
        logic [1:0]    low;
        logic [VB-1:0] av;
        logic [QB-1:0] q;
        logic          sat;
        logic          neg;
        logic          vz;
    } div_st_t;

    div_st_t st_reg [NS];
    div_st_t st_in  [NS];
    div_st_t st_next[NS];

    always_comb begin
        st_in[0].rem = lane.rem;
        st_in[0].low = lane.low;
        st_in[0].av  = lane.av;
        st_in[0].q   = '0;
        st_in[0].sat = lane.sat;
        st_in[0].neg = lane.neg;
        st_in[0].vz  = lane.vz;
        for (int k = 1; k < NS; k++) begin
            st_in[k] = st_reg[k-1];
        end
    end

    always_comb begin
        logic [VB:0] t;
        logic        b;
        for (int k = 0; k < NS; k++) begin
            st_next[k] = st_in[k];
            for (int i = 0; i < SP; i++) begin
                if (k * SP + i < QB) begin
                    b = (k * SP + i == 0) ? st_in[k].low[1] :
                        (k * SP + i == 1) ? st_in[k].low[0] : 1'b0;
                    t = {st_next[k].rem, b};
                    if (t >= {1'b0, st_next[k].av}) begin
                        st_next[k].rem = VB'(t - {1'b0, st_next[k].av});
                        st_next[k].q   = {st_next[k].q[QB-2:0], 1'b1};
                    end else begin
                        st_next[k].rem = t[VB-1:0];
                        st_next[k].q   = {st_next[k].q[QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign quot.q   = st_reg[NS-1].q;
    assign quot.sat = st_reg[NS-1].sat;
    assign quot.neg = st_reg[NS-1].neg;
    assign quot.vz  = st_reg[NS-1].vz;

endmodule

// ----- design/sbct_resolve.sv -----
module sbct_resolve (
    input  logic                                    aclk,
    input  logic                                    en,
    input  sbct_pkg::sbct_quot_t                    q_xe,
    input  sbct_pkg::sbct_quot_t                    q_xx,
    input  sbct_pkg::sbct_quot_t                    q_ye,
    input  sbct_pkg::sbct_quot_t                    q_yx,
    input  sbct_pkg::sbct_flags_t                   flags,
    output logic [sbct_pkg::TimeFracBits:0]         contact_time,
    output logic [1:0]                              normal_x,
    output logic [1:0]                              normal_y,
    output logic                                    hit
);
    localparam int TB = sbct_pkg::TimeBits;
    localparam int QB = sbct_pkg::QBits;

    logic signed [TB-1:0] xe_next, xx_next, ye_next, yx_next;
    logic signed [TB-1:0] xe_reg, ye_reg, entry_reg, exit_reg;
    sbct_pkg::sbct_flags_t fl_reg;
    logic                  nohit;
    logic [sbct_pkg::TimeFracBits:0] ct_reg;
    logic [1:0]            nx_reg, ny_reg;
    logic                  hit_reg;

    function automatic logic signed [TB-1:0] to_time(sbct_pkg::sbct_quot_t qt,
                                                     logic is_entry);
        logic [QB-1:0] mag;
        mag = (qt.sat || qt.q > sbct_pkg::QLim) ? sbct_pkg::QLim : qt.q;
        if (qt.vz) begin
            return is_entry ? -$signed(sbct_pkg::TInf) : $signed(sbct_pkg::TInf);
        end
        return qt.neg ? -$signed(TB'(mag)) : $signed(TB'(mag));
    endfunction

    always_comb begin
        xe_next = to_time(q_xe, 1'b1);
        xx_next = to_time(q_xx, 1'b0);
        ye_next = to_time(q_ye, 1'b1);
        yx_next = to_time(q_yx, 1'b0);
        nohit   = (entry_reg > exit_reg) || (xe_reg < 0 && ye_reg < 0) ||
                  (xe_reg > $signed(sbct_pkg::TOne)) || (ye_reg > $signed(sbct_pkg::TOne));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xe_reg    <= xe_next;
            ye_reg    <= ye_next;
            entry_reg <= (xe_next > ye_next) ? xe_next : ye_next;
            exit_reg  <= (xx_next < yx_next) ? xx_next : yx_next;
            fl_reg    <= flags;
            if (nohit) begin
                ct_reg  <= sbct_pkg::TOne[sbct_pkg::TimeFracBits:0];
                hit_reg <= 1'b0;
                nx_reg  <= sbct_pkg::NormNone;
                ny_reg  <= sbct_pkg::NormNone;
            end else begin
                ct_reg  <= entry_reg[sbct_pkg::TimeFracBits:0];
                hit_reg <= 1'b1;
                if (xe_reg > ye_reg && !fl_reg.edge_eq) begin
                    nx_reg <= fl_reg.gxe_neg ? sbct_pkg::NormPos : sbct_pkg::NormNeg;
                    ny_reg <= sbct_pkg::NormNone;
                end else begin
                    nx_reg <= sbct_pkg::NormNone;
                    ny_reg <= fl_reg.gye_neg ? sbct_pkg::NormPos : sbct_pkg::NormNeg;
                end
            end
        end
    end

    assign contact_time = ct_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign hit          = hit_reg;

endmodule

// ----- design/swept_box_collision_time_unit.sv -----
// Swept box collision time unit.
// Slave channel s_*: one request per box pair (moving box, velocity, still box).
// Master channel m_*: one result per request, in order: contact time Q1.16,
// x and y surface normals, hit flag.
// Stages: two gap/abs, six divider stages of three quotient bits each,
// two resolve stages. Throughput: one request per cycle while not stalled;
// four pipelined dividers run side by side.
// Reset (aresetn low, synchronous) clears all valid bits; data registers
// are not reset.
// Stall: when m_tready is low with a result pending, the whole pipeline
// holds and s_tready drops; empty stages do not fill during the stall.
// While the output register is empty the pipeline keeps moving, so s_tready
// stays high. Nothing is dropped or repeated.
module swept_box_collision_time_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mover_x, mover_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
    // target_x, target_y, target_width, target_height, zero pad
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // contact_time, normal_x, normal_y, hit, zero pad
    output logic [23:0]  m_tdata
);
    localparam int Lat = sbct_pkg::DivStages + 4;

    logic                  en;
    logic [Lat-1:0]        vld_reg;
    sbct_pkg::sbct_lane_t  l_xe, l_xx, l_ye, l_yx;
    sbct_pkg::sbct_quot_t  q_xe, q_xx, q_ye, q_yx;
    sbct_pkg::sbct_flags_t fl_gap;
    sbct_pkg::sbct_flags_t fl_reg [sbct_pkg::DivStages];
    logic [sbct_pkg::TimeFracBits:0] contact_time;
    logic [1:0]            normal_x, normal_y;
    logic                  hit;

    assign en       = m_tready || !vld_reg[Lat-1];
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];
    assign m_tdata  = {2'b00, hit, normal_y, normal_x, contact_time};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl_reg[0] <= fl_gap;
            for (int k = 1; k < sbct_pkg::DivStages; k++) begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    sbct_gap u_gap (
        .aclk          (aclk),
        .en            (en),
        .mover_x       (s_tdata[23:0]),
        .mover_y       (s_tdata[47:24]),
        .mover_width   (s_tdata[70:48]),
        .mover_height  (s_tdata[93:71]),
        .mover_vel_x   (s_tdata[113:94]),
        .mover_vel_y   (s_tdata[133:114]),
        .target_x      (s_tdata[157:134]),
        .target_y      (s_tdata[181:158]),
        .target_width  (s_tdata[204:182]),
        .target_height (s_tdata[227:205]),
        .lane_xe       (l_xe),
        .lane_xx       (l_xx),
        .lane_ye       (l_ye),
        .lane_yx       (l_yx),
        .flags         (fl_gap)
    );

    sbct_div u_div_xe (.aclk(aclk), .en(en), .lane(l_xe), .quot(q_xe));
    sbct_div u_div_xx (.aclk(aclk), .en(en), .lane(l_xx), .quot(q_xx));
    sbct_div u_div_ye (.aclk(aclk), .en(en), .lane(l_ye), .quot(q_ye));
    sbct_div u_div_yx (.aclk(aclk), .en(en), .lane(l_yx), .quot(q_yx));

    sbct_resolve u_resolve (
        .aclk         (aclk),
        .en           (en),
        .q_xe         (q_xe),
        .q_xx         (q_xx),
        .q_ye         (q_ye),
        .q_yx         (q_yx),
        .flags        (fl_reg[sbct_pkg::DivStages-1]),
        .contact_time (contact_time),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .hit          (hit)
    );

    a_nohit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit) |->
            (contact_time == sbct_pkg::TOne[sbct_pkg::TimeFracBits:0] &&
             normal_x == sbct_pkg::NormNone && normal_y == sbct_pkg::NormNone))
        else $error("miss result not clean");

    a_hit_one_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hit) |->
            ((normal_x == sbct_pkg::NormNone) != (normal_y == sbct_pkg::NormNone)))
        else $error("hit must carry exactly one normal");

    a_hit_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hit) |-> (contact_time <= sbct_pkg::TOne[sbct_pkg::TimeFracBits:0]))
        else $error("contact time beyond one frame");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

class collision_scoreboard;
    bit [23:0] pending[$];
    int        errors;
    int        checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    static function longint quotient(longint gap, longint vel);
        longint ag;
        longint av;
        longint q;
        ag = gap < 0 ? -gap : gap;
        av = vel < 0 ? -vel : vel;
        q  = (ag << sbct_pkg::TimeFracBits) / av;
        if (q > (longint'(2) << sbct_pkg::TimeFracBits))
            q = longint'(2) << sbct_pkg::TimeFracBits;
        return ((gap < 0) != (vel < 0)) ? -q : q;
    endfunction

    static function bit [23:0] sweep(bit [231:0] d);
        longint mx, my, mw, mh, vx, vy, tx, ty, tw, th;
        longint gxe, gxx, gye, gyx, xe, xx, ye, yx, entry, leave, one, inf;
        logic [1:0] nx, ny;
        bit [16:0]  t;
        bit         hit;
        mx = longint'($signed(d[23:0]));
        my = longint'($signed(d[47:24]));
        mw = longint'(d[70:48]);
        mh = longint'(d[93:71]);
        vx = longint'($signed(d[113:94]));
        vy = longint'($signed(d[133:114]));
        tx = longint'($signed(d[157:134]));
        ty = longint'($signed(d[181:158]));
        tw = longint'(d[204:182]);
        th = longint'(d[227:205]);
        one = longint'(1) << sbct_pkg::TimeFracBits;
        inf = 3 * one;
        nx = sbct_pkg::NormNone;
        ny = sbct_pkg::NormNone;
        if (vx > 0) begin
            gxe = tx - (mx + mw);
            gxx = (tx + tw) - mx;
        end else begin
            gxe = (tx + tw) - mx;
            gxx = tx - (mx + mw);
        end
        if (vy > 0) begin
            gye = (ty - th) - my;
            gyx = ty - (my - mh);
        end else begin
            gye = ty - (my - mh);
            gyx = (ty - th) - my;
        end
        if (vx == 0) begin
            xe = -inf;
            xx = inf;
        end else begin
            xe = quotient(gxe, vx);
            xx = quotient(gxx, vx);
        end
        if (vy == 0) begin
            ye = -inf;
            yx = inf;
        end else begin
            ye = quotient(gye, vy);
            yx = quotient(gyx, vy);
        end
        entry = xe > ye ? xe : ye;
        leave = xx < yx ? xx : yx;
        if (entry > leave || (xe < 0 && ye < 0) || xe > one || ye > one) begin
            t   = 17'(one);
            hit = 1'b0;
        end else begin
            t   = 17'(entry);
            hit = 1'b1;
            if (xe > ye && (my - mh) != ty)
                nx = gxe < 0 ? sbct_pkg::NormPos : sbct_pkg::NormNeg;
            else
                ny = gye < 0 ? sbct_pkg::NormPos : sbct_pkg::NormNeg;
        end
        return {2'b00, hit, ny, nx, t};
    endfunction

    function void note_request(bit [231:0] d);
        pending.push_back(sweep(d));
    endfunction

    task report(string what, longint want, longint got);
        errors++;
        if (errors <= 40)
            $display("mismatch %0s at result %0d: want %0h got %0h",
                     what, checked, want, got);
    endtask

    task check_result(bit [23:0] got);
        bit [23:0] want;
        checked++;
        if (pending.size() == 0) begin
            report("unexpected result", 0, got);
            return;
        end
        want = pending.pop_front();
        if (got[16:0] != want[16:0])
            report("contact_time", want[16:0], got[16:0]);
        if (got[18:17] != want[18:17])
            report("normal_x", want[18:17], got[18:17]);
        if (got[20:19] != want[20:19])
            report("normal_y", want[20:19], got[20:19]);
        if (got[21] != want[21])
            report("hit", want[21], got[21]);
    endtask
endclass

module testbench;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;

    collision_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    longint cycles;

    swept_box_collision_time_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 200000) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bit [231:0] pack_request(int mx, int my, int mw, int mh, int vx,
                                                int vy, int tx, int ty, int tw, int th);
        return {4'b0, th[22:0], tw[22:0], ty[23:0], tx[23:0], vy[19:0], vx[19:0],
                mh[22:0], mw[22:0], my[23:0], mx[23:0]};
    endfunction

    task automatic send_request(bit [231:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_request(d);
    endtask

    task automatic send_raw();
        bit [231:0] d;
        d = 232'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom});
        send_request({4'b0, d[227:0]});
    endtask

    // pairs near each other so contacts fall inside the frame
    task automatic send_near();
        int mx, my, vx, vy, tx, ty, span, vspan;
        int mw, mh, tw, th;
        span  = $urandom_range(3) == 0 ? 8000000 : 20000;
        vspan = $urandom_range(3) == 0 ? 524287 : 30000;
        mx = $urandom_range(2 * span) - span;
        my = $urandom_range(2 * span) - span;
        mw = $urandom_range(span / 2);
        mh = $urandom_range(span / 2);
        tx = mx + $urandom_range(span) - span / 2;
        ty = my + $urandom_range(span) - span / 2;
        tw = $urandom_range(span / 2);
        th = $urandom_range(span / 2);
        vx = $urandom_range(7) == 0 ? 0 : $urandom_range(2 * vspan) - vspan;
        vy = $urandom_range(7) == 0 ? 0 : $urandom_range(2 * vspan) - vspan;
        if ($urandom_range(5) == 0)
            ty = my - mh;
        send_request(pack_request(mx, my, mw, mh, vx, vy, tx, ty, tw, th));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, still mover, edge tie, saturation
        send_request(pack_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request('1);
        send_request(pack_request(24'h800000, 24'h800000, 0, 0, 20'h7ffff, 20'h7ffff,
                                  24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff));
        send_request(pack_request(24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff, 20'h80000,
                                  20'h80000, 24'h800000, 24'h800000, 0, 0));
        send_request(pack_request(0, 0, 256, 256, 512, 0, 512, 256, 256, 256));
        send_request(pack_request(0, 0, 256, 256, -512, 0, -512, 0, 256, 256));
        send_request(pack_request(0, 0, 256, 256, 0, 512, 0, 512, 256, 256));
        send_request(pack_request(0, 512, 256, 256, 0, -512, 0, 0, 256, 256));
        send_request(pack_request(0, 512, 256, 256, 512, -512, 256, 256, 256, 256));
        send_request(pack_request(0, 0, 256, 256, 512, 512, 512, 512, 256, 256));
        send_request(pack_request(0, 0, 256, 256, 1, 0, 8000000, 0, 256, 256));
        send_request(pack_request(0, 0, 256, 256, 256, 0, 600, 0, 256, 256));
        send_request(pack_request(0, 0, 256, 256, 100, 100, 0, 0, 256, 256));
        send_request(pack_request(1000, 1000, 256, 256, 20'h80000, 20'h80000, 0, 0, 256, 256));
        send_request(pack_request(0, 512, 256, 256, 1024, -256, 700, 256, 256, 256));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 10 : (phase == 1 ? 80 : 0);
            recv_idle_pct = phase == 0 ? 80 : (phase == 1 ? 10 : 0);
            for (int i = 0; i < 215; i++) begin
                if ($urandom_range(9) == 0)
                    send_raw();
                else
                    send_near();
                if (i == 100)
                    drain();
            end
        end
        drain();
        repeat (30) @(posedge aclk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
